FILE: hdl/fpa_pkg.sv
// Shared types, opcodes and saturation helpers for the fixed-point ALU.
package fpa_pkg;

  typedef enum logic [2:0] {
    CMD_ADD   = 3'd0,
    CMD_SUB   = 3'd1,
    CMD_MUL   = 3'd2,
    CMD_DIV   = 3'd3,
    CMD_MIN   = 3'd4,
    CMD_MAX   = 3'd5,
    CMD_INC   = 3'd6,
    CMD_TOINT = 3'd7
  } cmd_t;

  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  // Word carried down the pipe next to the divider state.
  typedef struct packed {
    cmd_t        cmd;
    logic        less;
    logic        equal;
    logic        greater;
    logic        neg;
    logic        dz;
    logic        eovf;
    logic [31:0] eres;
    logic [31:0] mb;
    logic [63:0] prod;
  } item_t;

  typedef struct packed {
    logic        ovf;
    logic [31:0] res;
  } sat_t;

  // Sign plus magnitude to 32-bit raw, clamped.
  function automatic sat_t saturate(input logic neg, input logic [64:0] mag);
    sat_t s;
    s.ovf = 1'b0;
    if (!neg && (mag > {33'd0, POS_LIMIT})) begin
      s.ovf = 1'b1;
      s.res = POS_LIMIT;
    end else if (neg && (mag > {33'd0, NEG_LIMIT})) begin
      s.ovf = 1'b1;
      s.res = NEG_LIMIT;
    end else if (neg) begin
      s.res = 32'd0 - mag[31:0];
    end else begin
      s.res = mag[31:0];
    end
    return s;
  endfunction

  // 33-bit two's complement sum back to 32 bits, clamped.
  function automatic sat_t wrap33(input logic [32:0] x);
    sat_t s;
    s.ovf = x[32] ^ x[31];
    if (s.ovf) begin
      s.res = x[32] ? NEG_LIMIT : POS_LIMIT;
    end else begin
      s.res = x[31:0];
    end
    return s;
  endfunction

endpackage

FILE: hdl/fpa_front.sv
// Front stages: operand decode, simple ops, compare flags, then the multiplier.
module fpa_front #(
  parameter int FRACT_BITS = 8,
  parameter int DW         = 41
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [2:0]           cmd,
  input  logic signed [31:0]   a_value,
  input  logic signed [31:0]   b_value,
  output logic                 out_valid,
  input  logic                 out_ready,
  output fpa_pkg::item_t       out_item,
  output logic [DW-1:0]        out_num
);

  logic           v1, v2, r1, r2;
  fpa_pkg::item_t it1, it1_next, it2, it2_next;
  logic [31:0]    ma1, ma, mb, toint;
  logic [DW-1:0]  num2;
  logic           a_neg, b_neg;
  fpa_pkg::sat_t  s_add, s_sub, s_inc;

  assign r2       = !v2 || out_ready;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_comb begin
    a_neg = a_value[31];
    b_neg = b_value[31];
    ma    = a_neg ? 32'd0 - a_value : a_value;
    mb    = b_neg ? 32'd0 - b_value : b_value;
    toint = ma >> FRACT_BITS;
    s_add = fpa_pkg::wrap33({a_value[31], a_value} + {b_value[31], b_value});
    s_sub = fpa_pkg::wrap33({a_value[31], a_value} - {b_value[31], b_value});
    s_inc = fpa_pkg::wrap33({a_value[31], a_value} + 33'd1);
    it1_next.cmd     = fpa_pkg::cmd_t'(cmd);
    it1_next.less    = a_value < b_value;
    it1_next.equal   = a_value == b_value;
    it1_next.greater = a_value > b_value;
    it1_next.neg     = a_neg ^ b_neg;
    it1_next.mb      = mb;
    it1_next.prod    = 64'd0;
    it1_next.dz      = 1'b0;
    it1_next.eovf    = 1'b0;
    it1_next.eres    = 32'd0;
    case (fpa_pkg::cmd_t'(cmd))
      fpa_pkg::CMD_ADD: begin
        it1_next.eres = s_add.res;
        it1_next.eovf = s_add.ovf;
      end
      fpa_pkg::CMD_SUB: begin
        it1_next.eres = s_sub.res;
        it1_next.eovf = s_sub.ovf;
      end
      fpa_pkg::CMD_INC: begin
        it1_next.eres = s_inc.res;
        it1_next.eovf = s_inc.ovf;
      end
      fpa_pkg::CMD_MIN: it1_next.eres = it1_next.greater ? b_value : a_value;
      fpa_pkg::CMD_MAX: it1_next.eres = it1_next.greater ? a_value : b_value;
      fpa_pkg::CMD_TOINT: it1_next.eres = a_neg ? 32'd0 - toint : toint;
      fpa_pkg::CMD_DIV: begin
        it1_next.dz   = (b_value == 32'sd0);
        it1_next.eres = a_neg ? fpa_pkg::NEG_LIMIT : fpa_pkg::POS_LIMIT;
      end
      default: it1_next.eres = 32'd0;
    endcase
  end

  // Second stage word: same as stage one plus the 32x32 magnitude product.
  always_comb begin
    it2_next      = it1;
    it2_next.prod = {32'd0, ma1} * {32'd0, it1.mb};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
    end
    if (r1 && in_valid) begin
      it1 <= it1_next;
      ma1 <= ma;
    end
    if (r2 && v1) begin
      it2  <= it2_next;
      num2 <= {ma1, {(FRACT_BITS + 1){1'b0}}};
    end
  end

  assign out_valid = v2;
  assign out_item  = it2;
  assign out_num   = num2;

endmodule

FILE: hdl/fpa_div_cell.sv
// One restoring-division cell: retires one quotient bit per stage.
module fpa_div_cell #(
  parameter int DW = 41
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fpa_pkg::item_t in_item,
  input  logic [DW-1:0]  in_num,
  input  logic [31:0]    in_rem,
  input  logic [DW-1:0]  in_q,
  output logic           out_valid,
  input  logic           out_ready,
  output fpa_pkg::item_t out_item,
  output logic [DW-1:0]  out_num,
  output logic [31:0]    out_rem,
  output logic [DW-1:0]  out_q
);

  logic          valid;
  logic [32:0]   shifted;
  logic [33:0]   diff;
  logic          take;

  assign in_ready = !valid || out_ready;
  assign shifted  = {in_rem, in_num[DW-1]};
  assign diff     = {1'b0, shifted} - {2'b00, in_item.mb};
  assign take     = !diff[33];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      out_item <= in_item;
      out_num  <= in_num << 1;
      out_rem  <= take ? diff[31:0] : shifted[31:0];
      out_q    <= {in_q[DW-2:0], take};
    end
  end

  assign out_valid = valid;

endmodule

FILE: hdl/fpa_out.sv
// Output stage: rounding, saturation, result select and output register.
module fpa_out #(
  parameter int FRACT_BITS = 8,
  parameter int DW         = 41
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  fpa_pkg::item_t      in_item,
  input  logic [DW-1:0]       in_q,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  result,
  output logic                less,
  output logic                equal,
  output logic                greater,
  output logic                overflowed,
  output logic                divide_by_zero
);

  logic          valid;
  logic [64:0]   mt, mr, dr;
  fpa_pkg::sat_t ms, ds, sel;

  assign in_ready = !valid || !out_stall;

  always_comb begin
    mt = {in_item.prod, 1'b0} >> FRACT_BITS;
    mr = (mt + 65'd1) >> 1;
    dr = ({{(65 - DW){1'b0}}, in_q} + 65'd1) >> 1;
    ms = fpa_pkg::saturate(in_item.neg, mr);
    ds = fpa_pkg::saturate(in_item.neg, dr);
    case (in_item.cmd)
      fpa_pkg::CMD_MUL: sel = ms;
      fpa_pkg::CMD_DIV: begin
        if (in_item.dz) begin
          sel.res = in_item.eres;
          sel.ovf = 1'b0;
        end else begin
          sel = ds;
        end
      end
      default: begin
        sel.res = in_item.eres;
        sel.ovf = in_item.eovf;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      result         <= sel.res;
      overflowed     <= sel.ovf;
      divide_by_zero <= in_item.dz;
      less           <= in_item.less;
      equal          <= in_item.equal;
      greater        <= in_item.greater;
    end
  end

  assign out_valid = valid;

endmodule

FILE: hdl/fixed_point_alu.sv
// Top level of the signed fixed-point ALU: front stages, divider cell row, output stage.
//
//   channel | valid     | stall     | word
//   --------+-----------+-----------+---------------------------------------------
//   in      | in_valid  | in_stall  | cmd, a_value, b_value
//   out     | out_valid | out_stall | result, less, equal, greater, overflowed,
//           |           |           | divide_by_zero
//
// One word per cycle sustained while out_stall stays low; every opcode passes through
// the two front stages, the row of restoring divider cells, one per
// quotient bit (FRACT_BITS + 33 of them), and the output register.
// Each stage holds its word until the next one frees up, so bubbles collapse and
// new words are taken while a finished result waits under out_stall.
// rst is synchronous and clears only the stage valid bits.
module fixed_point_alu #(
  parameter int FRACT_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] a_value,
  input  logic signed [31:0] b_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result,
  output logic               less,
  output logic               equal,
  output logic               greater,
  output logic               overflowed,
  output logic               divide_by_zero
);

  // Dividend (|a| << (FRACT_BITS + 1)) width; one cell per bit.
  localparam int DW = 33 + FRACT_BITS;

  logic           in_ready;
  logic           cv [0:DW];
  logic           cr [0:DW];
  fpa_pkg::item_t ci [0:DW];
  logic [DW-1:0]  cn [0:DW];
  logic [31:0]    cm [0:DW];
  logic [DW-1:0]  cq [0:DW];

  assign in_stall = !in_ready;

  fpa_front #(
    .FRACT_BITS (FRACT_BITS),
    .DW         (DW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .a_value   (a_value),
    .b_value   (b_value),
    .out_valid (cv[0]),
    .out_ready (cr[0]),
    .out_item  (ci[0]),
    .out_num   (cn[0])
  );

  // Remainder and quotient start at zero entering the first cell.
  assign cm[0] = 32'd0;
  assign cq[0] = '0;

  for (genvar k = 0; k < DW; k++) begin : g_cell
    fpa_div_cell #(
      .DW (DW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (cv[k]),
      .in_ready  (cr[k]),
      .in_item   (ci[k]),
      .in_num    (cn[k]),
      .in_rem    (cm[k]),
      .in_q      (cq[k]),
      .out_valid (cv[k+1]),
      .out_ready (cr[k+1]),
      .out_item  (ci[k+1]),
      .out_num   (cn[k+1]),
      .out_rem   (cm[k+1]),
      .out_q     (cq[k+1])
    );
  end

  fpa_out #(
    .FRACT_BITS (FRACT_BITS),
    .DW         (DW)
  ) u_out (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (cv[DW]),
    .in_ready       (cr[DW]),
    .in_item        (ci[DW]),
    .in_q           (cq[DW]),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result         (result),
    .less           (less),
    .equal          (equal),
    .greater        (greater),
    .overflowed     (overflowed),
    .divide_by_zero (divide_by_zero)
  );

`ifndef ASSERT_OFF
  a_one_compare: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({less, equal, greater}))
    else $error("compare flags not exclusive");

  a_dz_no_ovf: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(divide_by_zero && overflowed))
    else $error("divide by zero also flagged overflow");

  a_ovf_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && overflowed) |->
      (result == fpa_pkg::POS_LIMIT || result == fpa_pkg::NEG_LIMIT))
    else $error("overflow without saturated result");

  a_dz_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_by_zero) |->
      (result == fpa_pkg::POS_LIMIT || result == fpa_pkg::NEG_LIMIT))
    else $error("divide by zero without saturated result");
`endif

endmodule

FILE: tb/tb_fixed_point_alu.sv
// Testbench for the signed fixed-point ALU: directed and random words checked against a predictor.
`timescale 1ns / 1ps

module tb_fixed_point_alu;

  localparam int FRACT_BITS = 8;
  localparam int LATENCY    = FRACT_BITS + 36;

  // One expected result word.
  typedef struct packed {
    logic [31:0] res;
    logic        lt;
    logic        eq;
    logic        gt;
    logic        ovf;
    logic        dz;
  } alu_out_t;

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic [2:0]         cmd;
  logic signed [31:0] a_value;
  logic signed [31:0] b_value;
  logic               out_valid;
  logic               out_stall;
  logic signed [31:0] result;
  logic               less;
  logic               equal;
  logic               greater;
  logic               overflowed;
  logic               divide_by_zero;

  alu_out_t pending_q[$];
  int       mismatches;
  int       hold_cycles;   // long receiver hold-off, counted down by the sink
  bit       sink_random;

  fixed_point_alu #(.FRACT_BITS(FRACT_BITS)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .a_value(a_value), .b_value(b_value),
    .out_valid(out_valid), .out_stall(out_stall),
    .result(result), .less(less), .equal(equal), .greater(greater),
    .overflowed(overflowed), .divide_by_zero(divide_by_zero)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Clamp a signed magnitude to 32 bits; sets ovf on saturation.
  function automatic logic [31:0] clamp(input bit neg, input logic [63:0] mag,
                                        inout logic ovf);
    if (!neg && mag > 64'h7FFF_FFFF) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    if (neg && mag > 64'h8000_0000) begin
      ovf = 1'b1;
      return 32'h8000_0000;
    end
    return neg ? 32'd0 - mag[31:0] : mag[31:0];
  endfunction

  // Expected ALU result for one operation.
  function automatic alu_out_t alu_predict(input fpa_pkg::cmd_t op,
                                           input logic signed [31:0] a,
                                           input logic signed [31:0] b);
    alu_out_t    o;
    logic signed [63:0] wa, wb, s;
    logic [63:0] ma, mb, r;
    logic [127:0] p;
    bit          neg;
    wa = a;
    wb = b;
    ma = wa < 0 ? -wa : wa;
    mb = wb < 0 ? -wb : wb;
    neg = (a < 0) != (b < 0);
    o = '0;
    case (op)
      fpa_pkg::CMD_ADD: begin
        s = wa + wb;
        o.res = clamp(s < 0, s < 0 ? -s : s, o.ovf);
      end
      fpa_pkg::CMD_SUB: begin
        s = wa - wb;
        o.res = clamp(s < 0, s < 0 ? -s : s, o.ovf);
      end
      fpa_pkg::CMD_MUL: begin
        p = ({64'd0, ma} * {64'd0, mb}) << 1;
        p = p >> FRACT_BITS;
        r = (p[63:0] + 64'd1) >> 1;
        o.res = clamp(neg && r != 0, r, o.ovf);
      end
      fpa_pkg::CMD_DIV: begin
        if (b == 0) begin
          o.dz = 1'b1;
          o.res = a < 0 ? fpa_pkg::NEG_LIMIT : fpa_pkg::POS_LIMIT;
        end else begin
          r = (ma << (FRACT_BITS + 1)) / mb;
          r = (r + 64'd1) >> 1;
          o.res = clamp(neg && r != 0, r, o.ovf);
        end
      end
      fpa_pkg::CMD_MIN: o.res = a > b ? b : a;
      fpa_pkg::CMD_MAX: o.res = a > b ? a : b;
      fpa_pkg::CMD_INC: begin
        s = wa + 1;
        o.res = clamp(s < 0, s < 0 ? -s : s, o.ovf);
      end
      default: begin
        r = ma >> FRACT_BITS;
        o.res = clamp(a < 0 && r != 0, r, o.ovf);
      end
    endcase
    o.lt = a < b;
    o.eq = a == b;
    o.gt = a > b;
    return o;
  endfunction

  // Half the words with no gap, most others short gaps, a few long ones.
  function automatic int gap_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Offer one word and wait until it is taken; valid stays up for a following word.
  task automatic send_word(input fpa_pkg::cmd_t op, input logic [31:0] a,
                           input logic [31:0] b, input bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd      <= op;
    a_value  <= a;
    b_value  <= b;
    pending_q.push_back(alu_predict(op, a, b));
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random operand: corners, small values, or full range.
  function automatic logic [31:0] rand_operand();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 2);
      1: return 32'h8000_0000 + $urandom_range(0, 2);
      2: return 32'd0;
      3, 4: return $urandom_range(0, 2047) - 1024;
      5: return (32'($urandom_range(0, 255)) << 8) - 32'h8000;
      default: return $urandom();
    endcase
  endfunction

  // Receiver: random stall with an occasional long hold-off, or a requested hold-off.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else if (sink_random) begin
      if ($urandom_range(0, 99) < 2) hold_cycles <= $urandom_range(8, 40);
      out_stall <= ($urandom_range(0, 99) < 30) ? 1'b1 : 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker: compare each accepted word with the oldest expectation.
  always @(posedge clk) begin
    alu_out_t exp_w, got;
    if (!rst && out_valid && !out_stall) begin
      got = '{result, less, equal, greater, overflowed, divide_by_zero};
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        exp_w = pending_q.pop_front();
        if (got !== exp_w) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp res=%h l%b e%b g%b o%b z%b  got res=%h l%b e%b g%b o%b z%b",
                     exp_w.res, exp_w.lt, exp_w.eq, exp_w.gt, exp_w.ovf, exp_w.dz,
                     got.res, got.lt, got.eq, got.gt, got.ovf, got.dz);
        end
      end
    end
  end

  // Every opcode on extremes, equal operands, zero divisor and rounding halves.
  task automatic test_directed();
    fpa_pkg::cmd_t op;
    op = op.first();
    do begin
      send_word(op, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_word(op, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      op = op.next();
    end while (op != op.first());
    send_word(fpa_pkg::CMD_SUB, 32'h8000_0000, 32'd1, 1'b0);
    send_word(fpa_pkg::CMD_MUL, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_word(fpa_pkg::CMD_MUL, 32'h0000_0001, 32'h0000_0080, 1'b0);  // exact half rounds up
    send_word(fpa_pkg::CMD_MUL, 32'hFFFF_FFFF, 32'h0000_0080, 1'b0);  // negative half
    send_word(fpa_pkg::CMD_DIV, 32'd0, 32'd0, 1'b0);
    send_word(fpa_pkg::CMD_DIV, 32'hFFFF_FF00, 32'd0, 1'b0);
    send_word(fpa_pkg::CMD_DIV, 32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_word(fpa_pkg::CMD_DIV, 32'd1, 32'd512, 1'b0);
    send_word(fpa_pkg::CMD_TOINT, 32'hFFFF_FF01, 32'd5, 1'b0);         // truncates toward zero
    send_word(fpa_pkg::CMD_INC, 32'hFFFF_FFFF, 32'd0, 1'b0);
  endtask

  // Back-to-back words while the receiver holds off, so the pipe fills.
  task automatic test_backpressure();
    hold_cycles <= 200;
    repeat (120)
      send_word(fpa_pkg::cmd_t'($urandom_range(0, 7)), rand_operand(), rand_operand(), 1'b0);
  endtask

  // Random words with random gaps on both sides.
  task automatic test_random();
    logic [31:0] a;
    sink_random = 1'b1;
    repeat (1750) begin
      a = rand_operand();
      send_word(fpa_pkg::cmd_t'($urandom_range(0, 7)), a,
                ($urandom_range(0, 9) == 0) ? a : rand_operand(), 1'b1);
    end
  endtask

  initial begin
    rst         = 1'b1;
    in_valid    = 1'b0;
    cmd         = fpa_pkg::CMD_ADD;
    a_value     = '0;
    b_value     = '0;
    out_stall   = 1'b0;
    hold_cycles = 0;
    sink_random = 1'b0;
    mismatches  = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
